// File: hw/rtl/lsi_pkg.sv
// Shared types and constants for the line segment intersection pipeline.
// Depends on nothing; every other file in hw/rtl refers to it by scoped names.
`default_nettype none
package lsi_pkg;

	// Default number of fraction bits of the fixed point format (range 8 to 24).
	localparam int FRAC_BITS_DEF = 16;

	// Quotient bits produced by the divider, one per pipeline stage.
	localparam int QBITS = 33;

	typedef enum logic [1:0] {
		OUT_HIT      = 2'd0,
		OUT_CROSS    = 2'd1,
		OUT_PARALLEL = 2'd2
	} outcome_t;

	typedef enum logic [1:0] {
		AX_XY   = 2'd0,
		AX_XZ   = 2'd1,
		AX_YZ   = 2'd2,
		AX_NONE = 2'd3
	} axis_t;

	// Data that rides along with a word but is not touched by the divider.
	typedef struct packed {
		axis_t           axis;
		logic [2:0][31:0] p1;
		logic [2:0][31:0] d1;
	} side_t;

	// One restoring divider lane.
	typedef struct packed {
		logic             neg;
		logic             big;
		logic [63:0]      dmag;
		logic [63:0]      rem;
		logic [QBITS-1:0] nlow;
		logic [QBITS-1:0] quo;
	} div_lane_t;

	typedef struct packed {
		side_t     side;
		div_lane_t f1;
		div_lane_t f2;
	} div_word_t;

endpackage
`default_nettype wire

// File: hw/rtl/lsi_front.sv
// Front end: point differences, cross products, determinant selection and divider setup.
// Depends on lsi_pkg.
`default_nettype none
module lsi_front #(
	parameter int FRAC_BITS = lsi_pkg::FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic [2:0][31:0]      p1,
	input  wire logic [2:0][31:0]      d1,
	input  wire logic [2:0][31:0]      p2,
	input  wire logic [2:0][31:0]      d2,
	output logic                       out_valid,
	output lsi_pkg::div_word_t         out_word
);

	localparam int PA [3] = '{0, 0, 1};
	localparam int PB [3] = '{1, 2, 2};
	localparam int HI_SH  = lsi_pkg::QBITS - FRAC_BITS;

	// Stage 1: point differences.
	logic                     v_s1;
	logic [2:0][31:0]         p1_s1, d1_s1, d2_s1;
	logic signed [32:0]       e_s1 [3];

	// Stage 2: products for each axis pair.
	logic                     v_s2;
	logic [2:0][31:0]         p1_s2, d1_s2;
	logic signed [63:0]       da_s2 [3];
	logic signed [63:0]       db_s2 [3];
	logic signed [64:0]       n1a_s2 [3];
	logic signed [64:0]       n1b_s2 [3];
	logic signed [64:0]       n2a_s2 [3];
	logic signed [64:0]       n2b_s2 [3];

	// Stage 3: determinants and numerators.
	logic                     v_s3;
	logic [2:0][31:0]         p1_s3, d1_s3;
	logic signed [64:0]       det_s3 [3];
	logic signed [65:0]       n1_s3 [3];
	logic signed [65:0]       n2_s3 [3];

	// Stage 4: selected pair in sign and magnitude form.
	logic                     v_s4;
	lsi_pkg::side_t           side_s4;
	logic                     dneg_s4, n1neg_s4, n2neg_s4;
	logic [63:0]              dmag_s4, n1mag_s4, n2mag_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		p1_s1 <= p1;
		d1_s1 <= d1;
		d2_s1 <= d2;
		for (int k = 0; k < 3; k++) begin
			e_s1[k] <= $signed({p1[k][31], p1[k]}) - $signed({p2[k][31], p2[k]});
		end
	end

	always_ff @(posedge clk) begin
		p1_s2 <= p1_s1;
		d1_s2 <= d1_s1;
		for (int j = 0; j < 3; j++) begin
			da_s2[j]  <= $signed(d1_s1[PA[j]]) * $signed(d2_s1[PB[j]]);
			db_s2[j]  <= $signed(d1_s1[PB[j]]) * $signed(d2_s1[PA[j]]);
			n1a_s2[j] <= $signed(d2_s1[PA[j]]) * e_s1[PB[j]];
			n1b_s2[j] <= $signed(d2_s1[PB[j]]) * e_s1[PA[j]];
			n2a_s2[j] <= $signed(d1_s1[PA[j]]) * e_s1[PB[j]];
			n2b_s2[j] <= $signed(d1_s1[PB[j]]) * e_s1[PA[j]];
		end
	end

	always_ff @(posedge clk) begin
		p1_s3 <= p1_s2;
		d1_s3 <= d1_s2;
		for (int j = 0; j < 3; j++) begin
			det_s3[j] <= 65'(da_s2[j]) - 65'(db_s2[j]);
			n1_s3[j]  <= 66'(n1a_s2[j]) - 66'(n1b_s2[j]);
			n2_s3[j]  <= 66'(n2a_s2[j]) - 66'(n2b_s2[j]);
		end
	end

	// The first pair with a nonzero determinant wins.
	lsi_pkg::axis_t     axis_c;
	logic signed [64:0] det_c;
	logic signed [65:0] n1_c, n2_c;

	always_comb begin
		priority if (det_s3[0] != '0) begin
			axis_c = lsi_pkg::AX_XY;
			det_c  = det_s3[0];
			n1_c   = n1_s3[0];
			n2_c   = n2_s3[0];
		end else if (det_s3[1] != '0) begin
			axis_c = lsi_pkg::AX_XZ;
			det_c  = det_s3[1];
			n1_c   = n1_s3[1];
			n2_c   = n2_s3[1];
		end else if (det_s3[2] != '0) begin
			axis_c = lsi_pkg::AX_YZ;
			det_c  = det_s3[2];
			n1_c   = n1_s3[2];
			n2_c   = n2_s3[2];
		end else begin
			axis_c = lsi_pkg::AX_NONE;
			det_c  = '0;
			n1_c   = '0;
			n2_c   = '0;
		end
	end

	always_ff @(posedge clk) begin
		side_s4.axis <= axis_c;
		side_s4.p1   <= p1_s3;
		side_s4.d1   <= d1_s3;
		dneg_s4      <= det_c[64];
		dmag_s4      <= 64'(det_c[64] ? -det_c : det_c);
		n1neg_s4     <= n1_c[65];
		n1mag_s4     <= 64'(n1_c[65] ? -n1_c : n1_c);
		n2neg_s4     <= n2_c[65];
		n2mag_s4     <= 64'(n2_c[65] ? -n2_c : n2_c);
	end

	// Stage 5: overflow check and the divider's starting remainder.
	function automatic lsi_pkg::div_lane_t lane_init(logic nneg, logic [63:0] nmag,
			logic dneg, logic [63:0] dmag);
		lsi_pkg::div_lane_t l;
		logic [63:0]        sh;
		sh     = nmag << FRAC_BITS;
		l.neg  = nneg ^ dneg;
		l.rem  = nmag >> HI_SH;
		l.big  = (nmag >> HI_SH) >= dmag;
		l.dmag = dmag;
		l.nlow = sh[lsi_pkg::QBITS-1:0];
		l.quo  = '0;
		return l;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		out_word.side <= side_s4;
		out_word.f1   <= lane_init(n1neg_s4, n1mag_s4, dneg_s4, dmag_s4);
		out_word.f2   <= lane_init(n2neg_s4, n2mag_s4, dneg_s4, dmag_s4);
	end

endmodule
`default_nettype wire

// File: hw/rtl/lsi_div_step.sv
// One registered restoring division step for both factor lanes.
// Depends on lsi_pkg.
`default_nettype none
module lsi_div_step (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire lsi_pkg::div_word_t  in_word,
	output logic                     out_valid,
	output lsi_pkg::div_word_t       out_word
);

	function automatic lsi_pkg::div_lane_t lane_step(lsi_pkg::div_lane_t l);
		lsi_pkg::div_lane_t r;
		logic [64:0]        t;
		logic               ge;
		t      = {l.rem, l.nlow[lsi_pkg::QBITS-1]};
		ge     = t >= {1'b0, l.dmag};
		r      = l;
		r.rem  = ge ? 64'(t - {1'b0, l.dmag}) : t[63:0];
		r.nlow = l.nlow << 1;
		r.quo  = {l.quo[lsi_pkg::QBITS-2:0], ge};
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_word.side <= in_word.side;
		out_word.f1   <= lane_step(in_word.f1);
		out_word.f2   <= lane_step(in_word.f2);
	end

endmodule
`default_nettype wire

// File: hw/rtl/lsi_back.sv
// Back end: factor saturation, segment test, hit point multiply and saturation.
// Depends on lsi_pkg.
`default_nettype none
module lsi_back #(
	parameter int FRAC_BITS = lsi_pkg::FRAC_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire lsi_pkg::div_word_t  in_word,
	output logic                     out_valid,
	output logic [1:0]               outcome,
	output logic [1:0]               axis_pair,
	output logic [31:0]              factor_this,
	output logic [31:0]              factor_other,
	output logic [2:0][31:0]         hit
);

	localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

	function automatic logic [31:0] qsat(lsi_pkg::div_lane_t l);
		logic big;
		big = l.big | l.quo[lsi_pkg::QBITS-1];
		if (!l.neg) begin
			return (big || l.quo[31]) ? 32'h7FFF_FFFF : l.quo[31:0];
		end
		return (big || (l.quo[31] && (l.quo[30:0] != '0))) ? 32'h8000_0000
			: 32'(~l.quo[31:0] + 32'd1);
	endfunction

	function automatic logic in_seg(logic [31:0] f);
		return !f[31] && (f <= ONE);
	endfunction

	// Stage 1: quantized factors and outcome.
	logic               v_s1;
	lsi_pkg::outcome_t  outc_s1;
	lsi_pkg::axis_t     axis_s1;
	logic [31:0]        f1_s1, f2_s1;
	logic [2:0][31:0]   p1_s1, d1_s1;

	logic [31:0]        f1_c, f2_c;
	lsi_pkg::outcome_t  outc_c;

	always_comb begin
		f1_c = qsat(in_word.f1);
		f2_c = qsat(in_word.f2);
		priority if (in_word.side.axis == lsi_pkg::AX_NONE) begin
			outc_c = lsi_pkg::OUT_PARALLEL;
			f1_c   = '0;
			f2_c   = '0;
		end else if (in_seg(f1_c) && in_seg(f2_c)) begin
			outc_c = lsi_pkg::OUT_HIT;
		end else begin
			outc_c = lsi_pkg::OUT_CROSS;
		end
	end

	// Stage 2: f1 * d1 per axis.
	logic               v_s2;
	lsi_pkg::outcome_t  outc_s2;
	lsi_pkg::axis_t     axis_s2;
	logic [31:0]        f1_s2, f2_s2;
	logic [2:0][31:0]   p1_s2;
	logic signed [63:0] prod_s2 [3];

	// Stage 3: output register.
	logic               v_s3;
	lsi_pkg::outcome_t  outc_s3;
	lsi_pkg::axis_t     axis_s3;
	logic [31:0]        f1_s3, f2_s3;
	logic [2:0][31:0]   hit_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		outc_s1 <= outc_c;
		axis_s1 <= in_word.side.axis;
		f1_s1   <= f1_c;
		f2_s1   <= f2_c;
		p1_s1   <= in_word.side.p1;
		d1_s1   <= in_word.side.d1;
	end

	always_ff @(posedge clk) begin
		outc_s2 <= outc_s1;
		axis_s2 <= axis_s1;
		f1_s2   <= f1_s1;
		f2_s2   <= f2_s1;
		p1_s2   <= p1_s1;
		for (int k = 0; k < 3; k++) begin
			prod_s2[k] <= $signed(f1_s1) * $signed(d1_s1[k]);
		end
	end

	// Arithmetic shift rounds toward minus infinity, then the sum saturates.
	logic [2:0][31:0] hit_c;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic signed [63:0] s;
			logic signed [64:0] r;
			s = prod_s2[k] >>> FRAC_BITS;
			r = 65'(s) + 65'($signed(p1_s2[k]));
			if (outc_s2 != lsi_pkg::OUT_HIT) begin
				hit_c[k] = '0;
			end else if (r > 65'sh0_7FFF_FFFF) begin
				hit_c[k] = 32'h7FFF_FFFF;
			end else if (r < -65'sh0_8000_0000) begin
				hit_c[k] = 32'h8000_0000;
			end else begin
				hit_c[k] = r[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		outc_s3 <= outc_s2;
		axis_s3 <= axis_s2;
		f1_s3   <= f1_s2;
		f2_s3   <= f2_s2;
		hit_s3  <= hit_c;
	end

	assign out_valid    = v_s3;
	assign outcome      = outc_s3;
	assign axis_pair    = axis_s3;
	assign factor_this  = f1_s3;
	assign factor_other = f2_s3;
	assign hit          = hit_s3;

endmodule
`default_nettype wire

// File: hw/rtl/line_segment_intersection.sv
// From an accepted start to done a word passes 5 front stages, 33 divider stages and
// 3 back stages. The block takes one word per cycle; busy is always low.
// The divider retires one quotient bit per stage, which sets the depth.
// Reset (arst_n low) clears every valid bit at once; no word is in flight afterwards.
// The receiver cannot stall: each result appears for exactly one cycle with done high.
`default_nettype none
module line_segment_intersection #(
	parameter int FRAC_BITS = lsi_pkg::FRAC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] this_point_x,
	input  wire logic [31:0] this_point_y,
	input  wire logic [31:0] this_point_z,
	input  wire logic [31:0] this_dir_x,
	input  wire logic [31:0] this_dir_y,
	input  wire logic [31:0] this_dir_z,
	input  wire logic [31:0] other_point_x,
	input  wire logic [31:0] other_point_y,
	input  wire logic [31:0] other_point_z,
	input  wire logic [31:0] other_dir_x,
	input  wire logic [31:0] other_dir_y,
	input  wire logic [31:0] other_dir_z,
	output logic             done,
	output logic [1:0]       outcome,
	output logic [1:0]       axis_pair,
	output logic [31:0]      factor_this,
	output logic [31:0]      factor_other,
	output logic [31:0]      hit_x,
	output logic [31:0]      hit_y,
	output logic [31:0]      hit_z
);

	// The pipeline never stalls, so a new word is taken in every cycle.
	assign busy = 1'b0;

	logic [2:0][31:0] p1, d1, p2, d2;

	assign p1 = {this_point_z, this_point_y, this_point_x};
	assign d1 = {this_dir_z, this_dir_y, this_dir_x};
	assign p2 = {other_point_z, other_point_y, other_point_x};
	assign d2 = {other_dir_z, other_dir_y, other_dir_x};

	// The divider chain: entry 0 comes from the front end, each step adds one stage.
	logic               chain_v [lsi_pkg::QBITS+1];
	lsi_pkg::div_word_t chain_w [lsi_pkg::QBITS+1];

	lsi_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start),
		.p1       (p1),
		.d1       (d1),
		.p2       (p2),
		.d2       (d2),
		.out_valid(chain_v[0]),
		.out_word (chain_w[0])
	);

	for (genvar i = 0; i < lsi_pkg::QBITS; i++) begin : g_div
		lsi_div_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (chain_v[i]),
			.in_word  (chain_w[i]),
			.out_valid(chain_v[i+1]),
			.out_word (chain_w[i+1])
		);
	end

	// Saturation of the quotients, the segment test and the hit point.
	logic [2:0][31:0] hit;

	lsi_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (chain_v[lsi_pkg::QBITS]),
		.in_word     (chain_w[lsi_pkg::QBITS]),
		.out_valid   (done),
		.outcome     (outcome),
		.axis_pair   (axis_pair),
		.factor_this (factor_this),
		.factor_other(factor_other),
		.hit         (hit)
	);

	assign hit_x = hit[0];
	assign hit_y = hit[1];
	assign hit_z = hit[2];

endmodule
`default_nettype wire

// File: bench/testbench.sv
// Self-checking testbench for line_segment_intersection: directed line pairs, then random ones.
// Depends on lsi_pkg and the block's RTL. Expected results come from a predictor in this file.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = lsi_pkg::FRAC_BITS_DEF;
	localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 60;

	// One input word: p1 xyz, d1 xyz, p2 xyz, d2 xyz, in port order.
	typedef logic [11:0][31:0] pair_t;

	typedef struct packed {
		lsi_pkg::outcome_t outcome;
		lsi_pkg::axis_t    axis;
		logic [31:0]       f1;
		logic [31:0]       f2;
		logic [31:0]       hx;
		logic [31:0]       hy;
		logic [31:0]       hz;
	} crossing_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	pair_t pair_bus = '0;
	logic busy, done;
	logic [1:0] outcome, axis_pair;
	logic [31:0] factor_this, factor_other, hit_x, hit_y, hit_z;

	crossing_t expected_crossings[$];
	int errors = 0;
	int words_sent = 0;
	int words_checked = 0;
	int outcome_count[3] = '{0, 0, 0};
	int axis_count[4] = '{0, 0, 0, 0};
	int cycles = 0;
	// Percentage of cycles in which the sender holds off between words.
	int gap_pct = 0;

	always #2 clk = ~clk;

	line_segment_intersection dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.this_point_x(pair_bus[0]), .this_point_y(pair_bus[1]), .this_point_z(pair_bus[2]),
		.this_dir_x(pair_bus[3]), .this_dir_y(pair_bus[4]), .this_dir_z(pair_bus[5]),
		.other_point_x(pair_bus[6]), .other_point_y(pair_bus[7]),
		.other_point_z(pair_bus[8]),
		.other_dir_x(pair_bus[9]), .other_dir_y(pair_bus[10]), .other_dir_z(pair_bus[11]),
		.done(done), .outcome(outcome), .axis_pair(axis_pair),
		.factor_this(factor_this), .factor_other(factor_other),
		.hit_x(hit_x), .hit_y(hit_y), .hit_z(hit_z)
	);

	// Scaled quotient (num * 2^FRAC) / den, truncated toward zero and clamped to 32 bits.
	function automatic logic [31:0] scaled_quotient(input logic signed [127:0] num,
			input logic signed [127:0] den);
		logic [127:0] nm, dm, q;
		logic neg;
		neg = num[127] ^ den[127];
		nm = num[127] ? -num : num;
		dm = den[127] ? -den : den;
		q = (nm << FRAC) / dm;
		if (!neg)
			return (q > 128'h7fff_ffff) ? 32'h7fff_ffff : q[31:0];
		return (q > 128'h8000_0000) ? 32'h8000_0000 : -q[31:0];
	endfunction

	// Solves both factors on one axis pair; returns 0 when the determinant vanishes.
	function automatic logic solve_axis(input logic signed [31:0] d1a, d1b, d2a, d2b,
			p1a, p1b, p2a, p2b, output logic [31:0] f1, output logic [31:0] f2);
		logic signed [127:0] det, da, db;
		da = 128'(p1a) - 128'(p2a);
		db = 128'(p1b) - 128'(p2b);
		det = 128'(d1a) * 128'(d2b) - 128'(d1b) * 128'(d2a);
		f1 = '0;
		f2 = '0;
		if (det == 0)
			return 1'b0;
		f1 = scaled_quotient(128'(d2a) * db - 128'(d2b) * da, det);
		f2 = scaled_quotient(128'(d1a) * db - 128'(d1b) * da, det);
		return 1'b1;
	endfunction

	// p + floor(f * d / 2^FRAC), clamped to 32 bits.
	function automatic logic [31:0] hit_coord(input logic signed [31:0] p,
			input logic signed [31:0] f, input logic signed [31:0] d);
		logic signed [63:0] v, r;
		v = 64'(f) * 64'(d);
		r = 64'(p) + (v >>> FRAC);
		if (r > 64'sh7fff_ffff)
			return 32'h7fff_ffff;
		if (r < -64'sh8000_0000)
			return 32'h8000_0000;
		return r[31:0];
	endfunction

	function automatic crossing_t predict_crossing(input pair_t w);
		crossing_t c;
		logic signed [31:0] f1, f2;
		c = '0;
		if (solve_axis(w[3], w[4], w[9], w[10], w[0], w[1], w[6], w[7], c.f1, c.f2))
			c.axis = lsi_pkg::AX_XY;
		else if (solve_axis(w[3], w[5], w[9], w[11], w[0], w[2], w[6], w[8], c.f1, c.f2))
			c.axis = lsi_pkg::AX_XZ;
		else if (solve_axis(w[4], w[5], w[10], w[11], w[1], w[2], w[7], w[8], c.f1, c.f2))
			c.axis = lsi_pkg::AX_YZ;
		else
			c.axis = lsi_pkg::AX_NONE;
		f1 = c.f1;
		f2 = c.f2;
		if (c.axis == lsi_pkg::AX_NONE) begin
			c.outcome = lsi_pkg::OUT_PARALLEL;
			c.f1 = '0;
			c.f2 = '0;
		end else if (f1 >= 0 && f1 <= ONE && f2 >= 0 && f2 <= ONE) begin
			// Both factors inside the segments: report the crossing point.
			c.outcome = lsi_pkg::OUT_HIT;
			c.hx = hit_coord(w[0], f1, w[3]);
			c.hy = hit_coord(w[1], f1, w[4]);
			c.hz = hit_coord(w[2], f1, w[5]);
		end else begin
			c.outcome = lsi_pkg::OUT_CROSS;
		end
		return c;
	endfunction

	// Sends one word and records its expected result once the block takes it.
	// Start stays high afterwards unless the task leaves a gap, during which it lowers start.
	task automatic send_pair(input pair_t w);
		pair_bus <= w;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_crossings.push_back(predict_crossing(w));
		words_sent++;
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < gap_pct)
				@(posedge clk);
		end
	endtask

	// Results are sampled at the edge that ends their cycle; the receiver never stalls.
	always @(posedge clk) begin
		crossing_t e;
		if (arst_n && done) begin
			if (expected_crossings.size() == 0) begin
				$error("result word arrived with nothing expected");
				errors++;
			end else begin
				e = expected_crossings.pop_front();
				words_checked++;
				if (outcome != e.outcome) begin
					$error("outcome: expected %0d, got %0d", e.outcome, outcome);
					errors++;
				end
				if (axis_pair != e.axis) begin
					$error("axis_pair: expected %0d, got %0d", e.axis, axis_pair);
					errors++;
				end
				if (factor_this != e.f1) begin
					$error("factor_this: expected %h, got %h", e.f1, factor_this);
					errors++;
				end
				if (factor_other != e.f2) begin
					$error("factor_other: expected %h, got %h", e.f2, factor_other);
					errors++;
				end
				if (hit_x != e.hx) begin
					$error("hit_x: expected %h, got %h", e.hx, hit_x);
					errors++;
				end
				if (hit_y != e.hy) begin
					$error("hit_y: expected %h, got %h", e.hy, hit_y);
					errors++;
				end
				if (hit_z != e.hz) begin
					$error("hit_z: expected %h, got %h", e.hz, hit_z);
					errors++;
				end
				if (e.outcome <= lsi_pkg::OUT_PARALLEL)
					outcome_count[e.outcome]++;
				axis_count[e.axis]++;
			end
		end
	end

	// Watchdog against a hung pipeline.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	// Builds a pair from twelve coordinates, given and packed in port order.
	function automatic pair_t make_pair(input logic [31:0] p1x, p1y, p1z, d1x, d1y, d1z,
			p2x, p2y, p2z, d2x, d2y, d2z);
		return {d2z, d2y, d2x, p2z, p2y, p2x, d1z, d1y, d1x, p1z, p1y, p1x};
	endfunction

	task automatic wait_for_drain();
		start <= 1'b0;
		@(posedge clk);
		while (expected_crossings.size() != 0)
			@(posedge clk);
	endtask

	// Extremes, every axis pair, every outcome and the clamping paths.
	task automatic test_directed();
		logic [31:0] mx, mn, h;
		mx = 32'h7fff_ffff;
		mn = 32'h8000_0000;
		h = ONE >>> 1;
		// All zero: zero directions are degenerate.
		send_pair('0);
		send_pair({12{mx}});
		send_pair({12{mn}});
		send_pair({12{32'hffff_ffff}});
		// Plain hit in xy at half of each segment.
		send_pair(make_pair(0, 0, 0, ONE, 0, 0, h, -h, 0, 0, ONE, 0));
		// Factors exactly 0 and exactly 1.
		send_pair(make_pair(0, 0, 0, ONE, 0, 0, 0, 0, 0, 0, ONE, 0));
		send_pair(make_pair(0, 0, 0, ONE, 0, 0, ONE, -ONE, 0, 0, ONE, 0));
		// Rays cross beyond the first segment, and behind it.
		send_pair(make_pair(0, 0, 0, ONE, 0, 0, 3 * ONE, 0, 0, 0, ONE, 0));
		send_pair(make_pair(0, 0, 0, ONE, 0, 0, -ONE, 0, 0, 0, ONE, 0));
		// xy determinant zero, so the xz pair is used.
		send_pair(make_pair(0, 5, 0, ONE, 0, 0, h, 5, -h, 0, 0, ONE));
		// xy and xz both zero, so the yz pair is used.
		send_pair(make_pair(7, 0, 0, 0, ONE, 0, 7, h, -h, 0, 0, ONE));
		// Parallel, nonzero directions.
		send_pair(make_pair(0, 0, 0, ONE, ONE, 0, ONE, 0, 0, 2 * ONE, 2 * ONE, 0));
		// Tiny determinant with a large numerator clamps both factors, either sign.
		send_pair(make_pair(mx, mx, 0, 1, 0, 0, mn, mn, 0, 0, 1, 0));
		send_pair(make_pair(mn, mn, 0, 1, 0, 0, mx, mx, 0, 0, 1, 0));
		// Hits right at extreme start points, high and low, with zero factors along huge directions.
		send_pair(make_pair(mx, mx, mx, mx, 0, mx, mx, mx, mx, 0, ONE, 0));
		send_pair(make_pair(mn, mn, mn, mn, 0, mn, mn, mn, mn, 0, ONE, 0));
		// Negative direction with floor rounding of the step.
		send_pair(make_pair(0, 0, 0, -3, -ONE, 5, -1, h, 0, ONE, -ONE, 0));
		wait_for_drain();
	endtask

	function automatic logic [31:0] rand_q(input int span);
		return 32'($urandom_range(2 * span) - span);
	endfunction

	// Mostly consistent pairs built around a chosen crossing, with some noise mixed in.
	task automatic test_random(input int count, input int pct);
		pair_t w;
		logic signed [31:0] f1, f2;
		logic signed [63:0] step;
		int mode;
		gap_pct = pct;
		repeat (count) begin
			mode = $urandom_range(9);
			if (mode == 0) begin
				for (int i = 0; i < 12; i++)
					w[i] = $urandom;
			end else begin
				for (int i = 0; i < 3; i++) begin
					w[i] = rand_q(1 << 20);
					w[3 + i] = rand_q(1 << 18);
					w[9 + i] = rand_q(1 << 18);
				end
				// Force the fallback axis pairs and parallel lines now and then.
				if (mode == 1) begin
					w[4] = 0;
					w[10] = 0;
				end else if (mode == 2) begin
					w[3] = 0;
					w[9] = 0;
				end else if (mode == 3) begin
					w[11:9] = w[5:3];
				end
				f1 = 32'($urandom_range(1 << (FRAC + 1)) - (1 << (FRAC - 1)));
				f2 = 32'($urandom_range(1 << (FRAC + 1)) - (1 << (FRAC - 1)));
				if (mode == 4)
					f1 = ONE;
				for (int i = 0; i < 3; i++) begin
					step = (64'(f1) * 64'($signed(w[3 + i])) -
						64'(f2) * 64'($signed(w[9 + i]))) >>> FRAC;
					w[6 + i] = 32'(64'($signed(w[i])) + step);
				end
			end
			send_pair(w);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(210, 22);
		// Let the pipeline empty completely before carrying on.
		wait_for_drain();
		test_random(210, 88);
		test_random(210, 0);
		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d of %0d words: %0d hits, %0d outside crossings, %0d parallel.",
			words_checked, words_sent, outcome_count[0], outcome_count[1], outcome_count[2]);
		$display("Axis pairs used: xy %0d, xz %0d, yz %0d, none %0d.",
			axis_count[0], axis_count[1], axis_count[2], axis_count[3]);
		if (errors == 0 && expected_crossings.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
`default_nettype wire

// File: filelist.f
hw/rtl/lsi_pkg.sv
hw/rtl/lsi_front.sv
hw/rtl/lsi_div_step.sv
hw/rtl/lsi_back.sv
hw/rtl/line_segment_intersection.sv
bench/testbench.sv
